// ===== design/id3_pkg.sv =====
// Shared types and constants for the ID3v2 picture extractor.
// No dependencies; imported by every module of the block.
package id3_pkg;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_file;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] picture_byte;
      logic [1:0] image_format;
      logic       last_of_run;
   } rsp_type;

   // results produced by one request, at most two
   typedef struct packed {
      logic    first_valid;
      rsp_type first;
      logic    second_valid;
      rsp_type second;
   } push_type;

   localparam logic [1:0] KIND_PICTURE   = 2'd0;
   localparam logic [1:0] KIND_NOT_FOUND = 2'd1;
   localparam logic [1:0] KIND_TRUNCATED = 2'd2;

   localparam logic [1:0] FMT_JPG = 2'd0;
   localparam logic [1:0] FMT_PNG = 2'd1;
   localparam logic [1:0] FMT_BMP = 2'd2;
   localparam logic [1:0] FMT_GIF = 2'd3;

   localparam logic [27:0] MAX_TAG_RESET = 28'd33554432;
   localparam logic [23:0] TXT_PNG_UP    = 24'h504E47;
   localparam logic [23:0] TXT_PNG       = 24'h706E67;
   localparam logic [23:0] TXT_BMP       = 24'h626D70;
   localparam logic [23:0] TXT_GIF       = 24'h676966;

   typedef enum logic [11:0] {
      PH_HDR   = 12'b0000_0000_0001,
      PH_EXT   = 12'b0000_0000_0010,
      PH_SKIP  = 12'b0000_0000_0100,
      PH_FHDR  = 12'b0000_0000_1000,
      PH_ENC   = 12'b0000_0001_0000,
      PH_FMT   = 12'b0000_0010_0000,
      PH_MIME  = 12'b0000_0100_0000,
      PH_PTYPE = 12'b0000_1000_0000,
      PH_DESC  = 12'b0001_0000_0000,
      PH_IMAGE = 12'b0010_0000_0000,
      PH_DRAIN = 12'b0100_0000_0000,
      PH_DONE  = 12'b1000_0000_0000
   } phase_type;

   // expected frame id character: PIC for v2.2, APIC otherwise
   function automatic logic [7:0] frame_id_char(input logic v2, input logic [3:0] i);
      logic [7:0] c;
      c = 8'h00;
      if (v2) begin
         case (i[1:0])
            2'd0:    c = 8'h50;
            2'd1:    c = 8'h49;
            default: c = 8'h43;
         endcase
      end else begin
         case (i[1:0])
            2'd0:    c = 8'h41;
            2'd1:    c = 8'h50;
            2'd2:    c = 8'h49;
            default: c = 8'h43;
         endcase
      end
      return c;
   endfunction

endpackage

// ===== design/id3_parser.sv =====
// Byte-wise tag parser: state registers plus the per-byte step logic.
// Depends on id3_pkg.
module id3_parser (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  id3_pkg::req_type req_data,
   input  logic [27:0]      max_tag_size,
   output id3_pkg::push_type push
);
   import id3_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [3:0]  idx_ff, idx_in;
   logic [2:0]  ver_ff, ver_in;
   logic        ext_ff, ext_in;
   logic [31:0] sc_ff, sc_in;
   logic [27:0] tbl_ff, tbl_in;
   logic [31:0] fbl_ff, fbl_in;
   logic [31:0] skip_ff, skip_in;
   logic        match_ff, match_in;
   logic        wide_ff, wide_in;
   logic [1:0]  pair_ff, pair_in;
   logic [23:0] rtc_ff, rtc_in;
   logic [2:0]  hits_ff, hits_in;
   logic        fin_ff, fin_in;

   logic [7:0]  b;
   logic        v2, nf, sf, skip_req;
   logic [31:0] skip_n, sc_step, fdec, sdec, ext_n;
   logic [3:0]  hdr_len, id_len;
   logic [1:0]  fmt_code;
   logic [23:0] rtc_shift;

   always_comb begin
      b = req_data.data_byte;
      v2 = (ver_ff == 3'd2);
      hdr_len = v2 ? 4'd6 : 4'd10;
      id_len = v2 ? 4'd3 : 4'd4;
      fmt_code = hits_ff[0] ? FMT_PNG : hits_ff[1] ? FMT_BMP : hits_ff[2] ? FMT_GIF : FMT_JPG;
      sc_step = (ver_ff == 3'd4) ? {sc_ff[24:0], b[6:0]} : {sc_ff[23:0], b};
      fdec = fbl_ff - {31'd0, (fbl_ff != 32'd0)};
      sdec = skip_ff - {31'd0, (skip_ff != 32'd0)};
      rtc_shift = {rtc_ff[15:0], b};
      ext_n = 32'd0;

      phase_in = phase_ff; idx_in = idx_ff; ver_in = ver_ff; ext_in = ext_ff;
      sc_in = sc_ff; tbl_in = tbl_ff; fbl_in = fbl_ff; skip_in = skip_ff;
      match_in = match_ff; wide_in = wide_ff; pair_in = pair_ff; rtc_in = rtc_ff;
      hits_in = hits_ff; fin_in = fin_ff;
      nf = 1'b0; sf = 1'b0; skip_req = 1'b0; skip_n = 32'd0;
      push = '0;

      if (phase_ff == PH_HDR) begin
         if (idx_ff == 4'd0 && b != 8'h49) nf = 1'b1;
         if (idx_ff == 4'd1 && b != 8'h44) nf = 1'b1;
         if (idx_ff == 4'd2 && b != 8'h33) nf = 1'b1;
         if (idx_ff == 4'd3) begin
            if (b < 8'd2 || b > 8'd4) nf = 1'b1;
            else ver_in = b[2:0];
         end
         if (idx_ff == 4'd5) ext_in = b[6];
         if (idx_ff >= 4'd6) sc_in = {sc_ff[24:0], b[6:0]};
         if (!nf) begin
            if (idx_ff < 4'd9) begin
               idx_in = idx_ff + 4'd1;
            end else if (sc_in == 32'd0 || sc_in > {4'd0, max_tag_size}) begin
               nf = 1'b1;
            end else begin
               tbl_in = sc_in[27:0];
               if (ext_in) begin
                  if (sc_in < 32'd4) nf = 1'b1;
                  else begin
                     phase_in = PH_EXT;
                     idx_in = 4'd0;
                     sc_in = 32'd0;
                  end
               end else begin
                  sf = 1'b1;
               end
            end
         end
      end else if (phase_ff != PH_DONE) begin
         tbl_in = tbl_ff - {27'd0, (tbl_ff != 28'd0)};
         case (phase_ff)
            PH_EXT: begin
               sc_in = sc_step;
               idx_in = idx_ff + 4'd1;
               if (idx_in >= 4'd4) begin
                  ext_n = (sc_step < 32'd4) ? 32'd0 : sc_step - 32'd4;
                  if (ext_n > {4'd0, tbl_in}) nf = 1'b1;
                  else begin
                     skip_req = 1'b1;
                     skip_n = ext_n;
                  end
               end
            end
            PH_SKIP: begin
               skip_in = sdec;
               if (sdec == 32'd0) sf = 1'b1;
            end
            PH_FHDR: begin
               if (idx_ff < id_len) begin
                  if (idx_ff == 4'd0 && b == 8'd0) nf = 1'b1;
                  if (b != frame_id_char(v2, idx_ff)) match_in = 1'b0;
               end else if (idx_ff < id_len + (v2 ? 4'd3 : 4'd4)) begin
                  sc_in = sc_step;
               end
               if (!nf) begin
                  if (idx_ff + 4'd1 < hdr_len) begin
                     idx_in = idx_ff + 4'd1;
                  end else if (sc_in == 32'd0 || sc_in > {4'd0, tbl_in}) begin
                     nf = 1'b1;
                  end else begin
                     fbl_in = sc_in;
                     if (match_in && sc_in > (v2 ? 32'd6 : 32'd4)) phase_in = PH_ENC;
                     else begin
                        skip_req = 1'b1;
                        skip_n = sc_in;
                     end
                  end
               end
            end
            PH_IMAGE: begin
               fbl_in = fdec;
               push.first_valid = 1'b1;
               push.first.kind = KIND_PICTURE;
               push.first.picture_byte = b;
               push.first.image_format = fmt_code;
               push.first.last_of_run = (fdec == 32'd0);
               if (fdec == 32'd0) begin
                  fin_in = 1'b1;
                  phase_in = (tbl_in != 28'd0) ? PH_DRAIN : PH_DONE;
               end
            end
            PH_DRAIN: begin
               if (tbl_in == 28'd0) phase_in = PH_DONE;
            end
            default: begin
               fbl_in = fdec;
               case (phase_ff)
                  PH_ENC: begin
                     wide_in = (b == 8'd1 || b == 8'd2);
                     rtc_in = 24'd0;
                     hits_in = 3'd0;
                     idx_in = 4'd0;
                     phase_in = v2 ? PH_FMT : PH_MIME;
                  end
                  PH_FMT: begin
                     rtc_in = rtc_shift;
                     idx_in = idx_ff + 4'd1;
                     if (idx_in >= 4'd3) begin
                        hits_in = {2'd0, (rtc_shift == TXT_PNG_UP)};
                        phase_in = PH_PTYPE;
                     end
                  end
                  PH_MIME: begin
                     if (b == 8'd0) phase_in = PH_PTYPE;
                     else begin
                        rtc_in = rtc_shift;
                        hits_in = hits_ff | {(rtc_shift == TXT_GIF), (rtc_shift == TXT_BMP),
                                             (rtc_shift == TXT_PNG)};
                     end
                  end
                  PH_PTYPE: begin
                     pair_in = 2'd0;
                     phase_in = PH_DESC;
                  end
                  default: begin
                     if (wide_ff) begin
                        if (pair_ff == 2'd0) pair_in = (b == 8'd0) ? 2'd2 : 2'd1;
                        else begin
                           if (pair_ff == 2'd2 && b == 8'd0) phase_in = PH_IMAGE;
                           pair_in = 2'd0;
                        end
                     end else if (b == 8'd0) begin
                        phase_in = PH_IMAGE;
                     end
                  end
               endcase
               if (fdec == 32'd0) sf = 1'b1;
            end
         endcase
      end

      if (skip_req) begin
         if (skip_n == 32'd0) sf = 1'b1;
         else begin
            skip_in = skip_n;
            phase_in = PH_SKIP;
         end
      end
      if (sf) begin
         if (tbl_in < {24'd0, hdr_len}) nf = 1'b1;
         else begin
            phase_in = PH_FHDR;
            idx_in = 4'd0;
            match_in = 1'b1;
            sc_in = 32'd0;
         end
      end
      if (nf) begin
         push.first_valid = 1'b1;
         push.first.kind = KIND_NOT_FOUND;
         push.first.picture_byte = 8'd0;
         push.first.image_format = FMT_JPG;
         push.first.last_of_run = 1'b1;
         fin_in = 1'b1;
         phase_in = PH_DONE;
      end

      if (req_data.end_of_file) begin
         // status goes after any picture byte of this request
         if (!fin_in || phase_in == PH_DRAIN) begin
            push.second_valid = 1'b1;
            push.second.kind = (!fin_in && phase_in == PH_HDR) ? KIND_NOT_FOUND
                                                               : KIND_TRUNCATED;
            push.second.picture_byte = 8'd0;
            push.second.image_format = FMT_JPG;
            push.second.last_of_run = 1'b1;
         end
         phase_in = PH_HDR; idx_in = 4'd0; ver_in = 3'd0; ext_in = 1'b0;
         sc_in = 32'd0; tbl_in = 28'd0; fbl_in = 32'd0; skip_in = 32'd0;
         match_in = 1'b0; wide_in = 1'b0; pair_in = 2'd0; rtc_in = 24'd0;
         hits_in = 3'd0; fin_in = 1'b0;
      end
      if (!step) push = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HDR; idx_ff <= 4'd0; ver_ff <= 3'd0; ext_ff <= 1'b0;
         sc_ff <= 32'd0; tbl_ff <= 28'd0; fbl_ff <= 32'd0; skip_ff <= 32'd0;
         match_ff <= 1'b0; wide_ff <= 1'b0; pair_ff <= 2'd0; rtc_ff <= 24'd0;
         hits_ff <= 3'd0; fin_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; idx_ff <= idx_in; ver_ff <= ver_in; ext_ff <= ext_in;
         sc_ff <= sc_in; tbl_ff <= tbl_in; fbl_ff <= fbl_in; skip_ff <= skip_in;
         match_ff <= match_in; wide_ff <= wide_in; pair_ff <= pair_in; rtc_ff <= rtc_in;
         hits_ff <= hits_in; fin_ff <= fin_in;
      end
   end

endmodule

// ===== design/id3_rsp_fifo.sv =====
// Four-entry result queue taking up to two results per cycle.
// Depends on id3_pkg.
module id3_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  id3_pkg::push_type push,
   input  logic              pop,
   output logic              rsp_valid,
   output id3_pkg::rsp_type  rsp_data,
   output logic              almost_full
);
   import id3_pkg::*;

   rsp_type    mem_ff [4];
   logic [1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [2:0] count_ff, count_in;
   logic [1:0] n_push;
   logic [1:0] second_ptr;

   always_comb begin
      // second result lands right after the first, or at the tail alone
      n_push = {1'b0, push.first_valid} + {1'b0, push.second_valid};
      second_ptr = push.first_valid ? wr_ptr_ff + 2'd1 : wr_ptr_ff;
      wr_ptr_in = wr_ptr_ff + n_push;
      rd_ptr_in = rd_ptr_ff + {1'b0, pop};
      count_in = count_ff + {1'b0, n_push} - {2'd0, pop};
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) mem_ff[wr_ptr_ff] <= push.first;
      if (push.second_valid) mem_ff[second_ptr] <= push.second;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 2'd0;
         rd_ptr_ff <= 2'd0;
         count_ff <= 3'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   assign rsp_valid = (count_ff != 3'd0);
   assign rsp_data = mem_ff[rd_ptr_ff];
   assign almost_full = (count_ff > 3'd2);

endmodule

// ===== design/id3v2_picture_extractor_unit.sv =====
// ID3v2 picture extractor: one file byte per request, image bytes out.
// Latency: results of a request are visible the cycle after it is accepted.
// Throughput: one request per cycle; the four-entry result queue stalls
// requests only while it holds three or more results.
// Reset (synchronous) returns the parser to the tag header and max_tag_size to 32 MiB.
module id3v2_picture_extractor_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  id3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output id3_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [27:0]      csr_data
);
   import id3_pkg::*;

   logic [27:0] max_tag_ff;
   push_type    push;
   logic        step, pop, almost_full;

   assign csr_ready = 1'b1;
   assign req_stall = almost_full;
   assign step = req_valid && !req_stall;
   assign pop = rsp_valid && !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) max_tag_ff <= MAX_TAG_RESET;
      else if (csr_valid && csr_ready) max_tag_ff <= csr_data;
   end

   id3_parser u_parser (
      .clock(clock), .reset(reset), .step(step), .req_data(req_data),
      .max_tag_size(max_tag_ff), .push(push)
   );

   id3_rsp_fifo u_fifo (
      .clock(clock), .reset(reset), .push(push), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .almost_full(almost_full)
   );

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.kind != KIND_PICTURE |->
         rsp_data.last_of_run && rsp_data.picture_byte == 8'd0)
      else $error("status result without last mark");

   a_stall_has_rsp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty queue");

   a_idle_no_push: assert property (@(posedge clock) disable iff (reset)
      !step |-> !push.first_valid && !push.second_valid)
      else $error("result pushed without a request");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("queue not empty after reset");

endmodule

// ===== dv/id3_stream_checker.sv =====
// Watches the request, result and csr channels of the ID3v2 picture extractor,
// predicts each result from the accepted file bytes and compares. Needs id3_pkg.
module id3_stream_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  id3_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  id3_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   input  logic             csr_ready,
   input  logic [27:0]      csr_data,
   output int               errors,
   output int               pending
);
   import id3_pkg::*;

   rsp_type     expected_rsp[$];

   logic [27:0] max_tag;
   phase_type   phase;
   logic [3:0]  fld_idx;
   logic [2:0]  version;
   logic        has_ext;
   logic [31:0] size_acc;
   logic [27:0] tag_left;
   logic [31:0] frame_left;
   logic [31:0] skip_left;
   logic        id_match;
   logic        wide;
   logic [1:0]  pair_pos;
   logic [23:0] last_chars;
   logic [2:0]  fmt_hits;
   logic        done;

   initial errors = 0;

   function automatic void add_rsp(logic [1:0] k, logic [7:0] b, logic [1:0] f, logic l);
      rsp_type r;
      r.kind = k;
      r.picture_byte = b;
      r.image_format = f;
      r.last_of_run = l;
      expected_rsp = {expected_rsp, r};
   endfunction

   function automatic void clear_parser();
      phase = PH_HDR;
      fld_idx = '0;
      version = '0;
      has_ext = 1'b0;
      size_acc = '0;
      tag_left = '0;
      frame_left = '0;
      skip_left = '0;
      id_match = 1'b0;
      wide = 1'b0;
      pair_pos = '0;
      last_chars = '0;
      fmt_hits = '0;
      done = 1'b0;
   endfunction

   function automatic void give_up();
      add_rsp(KIND_NOT_FOUND, 8'h00, FMT_JPG, 1'b1);
      done = 1'b1;
      phase = PH_DONE;
   endfunction

   function automatic void next_frame();
      if (tag_left < ((version == 3'd2) ? 28'd6 : 28'd10)) begin
         give_up();
      end else begin
         phase = PH_FHDR;
         fld_idx = '0;
         id_match = 1'b1;
         size_acc = '0;
      end
   endfunction

   function automatic void skip_n(logic [31:0] n);
      if (n == 0) begin
         next_frame();
      end else begin
         skip_left = n;
         phase = PH_SKIP;
      end
   endfunction

   function automatic logic [1:0] format_code();
      if (fmt_hits[0]) return FMT_PNG;
      if (fmt_hits[1]) return FMT_BMP;
      if (fmt_hits[2]) return FMT_GIF;
      return FMT_JPG;
   endfunction

   function automatic void tag_header_byte(logic [7:0] b);
      if ((fld_idx == 0 && b != "I") || (fld_idx == 1 && b != "D") ||
          (fld_idx == 2 && b != "3") || (fld_idx == 3 && (b < 2 || b > 4))) begin
         give_up();
         return;
      end
      if (fld_idx == 3) version = b[2:0];
      if (fld_idx == 5) has_ext = b[6];
      if (fld_idx >= 6) size_acc = (size_acc << 7) | (b & 8'h7F);
      if (fld_idx < 9) begin
         fld_idx = fld_idx + 1;
         return;
      end
      if (size_acc == 0 || size_acc > max_tag) begin
         give_up();
         return;
      end
      tag_left = size_acc[27:0];
      if (has_ext) begin
         if (tag_left < 4) begin
            give_up();
            return;
         end
         phase = PH_EXT;
         fld_idx = '0;
         size_acc = '0;
      end else begin
         next_frame();
      end
   endfunction

   function automatic void frame_header_byte(logic [7:0] b);
      logic        v2;
      logic [3:0]  id_len;
      logic [3:0]  hdr_len;
      logic [31:0] apic;
      logic [23:0] pic;
      logic [7:0]  want;
      v2 = (version == 3'd2);
      id_len = v2 ? 4'd3 : 4'd4;
      hdr_len = v2 ? 4'd6 : 4'd10;
      apic = "APIC";
      pic = "PIC";
      if (fld_idx < id_len) begin
         if (fld_idx == 0 && b == 0) begin
            give_up();
            return;
         end
         want = v2 ? pic[23 - 8 * fld_idx -: 8] : apic[31 - 8 * fld_idx -: 8];
         if (b != want) id_match = 1'b0;
      end else if (fld_idx < id_len + (v2 ? 4'd3 : 4'd4)) begin
         if (version == 3'd4) size_acc = (size_acc << 7) | (b & 8'h7F);
         else size_acc = (size_acc << 8) | b;
      end
      if (fld_idx + 1 < hdr_len) begin
         fld_idx = fld_idx + 1;
         return;
      end
      if (size_acc == 0 || size_acc > tag_left) begin
         give_up();
         return;
      end
      frame_left = size_acc;
      if (id_match && size_acc > (v2 ? 32'd6 : 32'd4)) phase = PH_ENC;
      else skip_n(size_acc);
   endfunction

   function automatic void picture_field_byte(logic [7:0] b);
      case (phase)
         PH_ENC: begin
            wide = (b == 1 || b == 2);
            last_chars = '0;
            fmt_hits = '0;
            fld_idx = '0;
            phase = (version == 3'd2) ? PH_FMT : PH_MIME;
         end
         PH_FMT: begin
            last_chars = {last_chars[15:0], b};
            fld_idx = fld_idx + 1;
            if (fld_idx >= 3) begin
               fmt_hits = (last_chars == TXT_PNG_UP) ? 3'd1 : 3'd0;
               phase = PH_PTYPE;
            end
         end
         PH_MIME: begin
            if (b == 0) begin
               phase = PH_PTYPE;
            end else begin
               last_chars = {last_chars[15:0], b};
               if (last_chars == TXT_PNG) fmt_hits[0] = 1'b1;
               if (last_chars == TXT_BMP) fmt_hits[1] = 1'b1;
               if (last_chars == TXT_GIF) fmt_hits[2] = 1'b1;
            end
         end
         PH_PTYPE: begin
            pair_pos = '0;
            phase = PH_DESC;
         end
         default: begin
            if (wide) begin
               if (pair_pos == 0) begin
                  pair_pos = (b == 0) ? 2'd2 : 2'd1;
               end else begin
                  if (pair_pos == 2 && b == 0) phase = PH_IMAGE;
                  pair_pos = '0;
               end
            end else if (b == 0) begin
               phase = PH_IMAGE;
            end
         end
      endcase
   endfunction

   function automatic void tag_body_byte(logic [7:0] b);
      logic [31:0] n;
      if (tag_left > 0) tag_left = tag_left - 1;
      case (phase)
         PH_EXT: begin
            if (version == 3'd4) size_acc = (size_acc << 7) | (b & 8'h7F);
            else size_acc = (size_acc << 8) | b;
            fld_idx = fld_idx + 1;
            if (fld_idx >= 4) begin
               n = (size_acc < 4) ? 32'd0 : size_acc - 4;
               if (n > tag_left) give_up();
               else skip_n(n);
            end
         end
         PH_SKIP: begin
            if (skip_left > 0) skip_left = skip_left - 1;
            if (skip_left == 0) next_frame();
         end
         PH_FHDR: frame_header_byte(b);
         PH_IMAGE: begin
            if (frame_left > 0) frame_left = frame_left - 1;
            if (frame_left == 0) begin
               add_rsp(KIND_PICTURE, b, format_code(), 1'b1);
               done = 1'b1;
               phase = (tag_left > 0) ? PH_DRAIN : PH_DONE;
            end else begin
               add_rsp(KIND_PICTURE, b, format_code(), 1'b0);
            end
         end
         PH_DRAIN: begin
            if (tag_left == 0) phase = PH_DONE;
         end
         default: begin
            if (frame_left > 0) frame_left = frame_left - 1;
            picture_field_byte(b);
            if (frame_left == 0) next_frame();
         end
      endcase
   endfunction

   function automatic void parse_byte(logic [7:0] b, logic eof);
      if (phase == PH_HDR) tag_header_byte(b);
      else if (phase != PH_DONE) tag_body_byte(b);
      if (eof) begin
         if (!done) add_rsp((phase == PH_HDR) ? KIND_NOT_FOUND : KIND_TRUNCATED,
                            8'h00, FMT_JPG, 1'b1);
         else if (phase == PH_DRAIN) add_rsp(KIND_TRUNCATED, 8'h00, FMT_JPG, 1'b1);
         clear_parser();
      end
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         expected_rsp.delete();
         clear_parser();
         max_tag = MAX_TAG_RESET;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsp.size() == 0) begin
               $display("%0t: unexpected result %p", $time, rsp_data);
               errors++;
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_data.kind != want.kind) begin
                  $display("%0t: kind expected %0d got %0d", $time, want.kind, rsp_data.kind);
                  errors++;
               end
               if (rsp_data.picture_byte != want.picture_byte) begin
                  $display("%0t: picture_byte expected %h got %h", $time,
                           want.picture_byte, rsp_data.picture_byte);
                  errors++;
               end
               if (rsp_data.image_format != want.image_format) begin
                  $display("%0t: image_format expected %0d got %0d", $time,
                           want.image_format, rsp_data.image_format);
                  errors++;
               end
               if (rsp_data.last_of_run != want.last_of_run) begin
                  $display("%0t: last_of_run expected %0d got %0d", $time,
                           want.last_of_run, rsp_data.last_of_run);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) max_tag = csr_data;
         if (req_valid && !req_stall) parse_byte(req_data.data_byte, req_data.end_of_file);
      end
      pending = expected_rsp.size();
   end

endmodule

// ===== dv/testbench.sv =====
// Top of the picture extractor testbench: clock, reset, file stimulus, csr writes
// and verdict. Needs id3_pkg, id3v2_picture_extractor_unit and id3_stream_checker.
module testbench;
   import id3_pkg::*;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_stall;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [27:0] csr_data;
   int          errors;
   int          pending;

   logic [7:0]  file_q[$];
   int          bytes_sent;
   bit          calm;
   bit          squeeze;

   id3v2_picture_extractor_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   id3_stream_checker chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .errors(errors), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   // result side: random stalls, one long hold-off when asked
   initial begin
      bit held;
      held = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if (squeeze && !held) begin
            held = 1'b1;
            rsp_stall <= 1'b1;
            repeat (150) @(posedge clock);
         end
         rsp_stall <= !calm && ($urandom_range(99) < 17);
      end
   end

   task automatic append_byte(ref logic [7:0] q[$], input logic [7:0] v);
      q = {q, v};
   endtask

   task automatic put_size(ref logic [7:0] q[$], input int unsigned v, input int n,
                           input bit synchsafe);
      for (int k = n - 1; k >= 0; k--)
         append_byte(q, synchsafe ? 8'((v >> (7 * k)) & 32'h7F)
                                  : 8'((v >> (8 * k)) & 32'hFF));
   endtask

   task automatic put_text(ref logic [7:0] q[$], input string s);
      for (int i = 0; i < s.len(); i++) append_byte(q, s[i]);
   endtask

   task automatic put_frame_hdr(ref logic [7:0] q[$], input int ver, input string id,
                                input int unsigned size);
      put_text(q, id);
      put_size(q, size, (ver == 2) ? 3 : 4, ver == 4);
      if (ver != 2) begin
         append_byte(q, 8'h00);
         append_byte(q, 8'h00);
      end
   endtask

   task automatic header_only(input int ver, input int unsigned size, input int extra);
      file_q.delete();
      put_text(file_q, "ID3");
      append_byte(file_q, ver[7:0]);
      append_byte(file_q, 8'h00);
      append_byte(file_q, 8'h00);
      put_size(file_q, size, 4, 1'b1);
      repeat (extra) append_byte(file_q, 8'($urandom));
   endtask

   // mode: 0 clean, 1 cut short, 2 one byte corrupted, 3 picture frame oversized,
   // 4 padding ahead of the picture, 5 no picture frame, 6 pure noise
   task automatic make_file(input int ver, input bit ext, input int mode);
      logic [7:0] body[$];
      logic [7:0] pic[$];
      int unsigned n;
      int unsigned enc;
      string mimes[6];
      mimes = '{"image/png", "image/bmp", "image/gif", "image/jpeg", "", "xpngbmp"};
      file_q.delete();
      if (mode == 6) begin
         repeat ($urandom_range(1, 12)) append_byte(file_q, 8'($urandom));
         if ($urandom_range(1) == 1) file_q[0] = "I";
         return;
      end
      if (ext) begin
         n = $urandom_range(0, 10);
         put_size(body, n, 4, ver == 4);
         repeat ((n < 4) ? 0 : n - 4) append_byte(body, 8'($urandom));
      end
      repeat ($urandom_range(0, 2)) begin
         n = $urandom_range(1, 8);
         put_frame_hdr(body, ver, (ver == 2) ? "TT2" : "TIT2", n);
         repeat (n) append_byte(body, 8'($urandom));
      end
      if ($urandom_range(3) == 0) begin
         put_frame_hdr(body, ver, (ver == 2) ? "PIC" : "APIC", 3);
         repeat (3) append_byte(body, 8'($urandom));
      end
      if (mode == 4) repeat ($urandom_range(1, 3)) append_byte(body, 8'h00);
      if (mode != 5) begin
         enc = $urandom_range(0, 3);
         append_byte(pic, enc[7:0]);
         if (ver == 2) begin
            case ($urandom_range(3))
               0: put_text(pic, "PNG");
               1: put_text(pic, "JPG");
               2: put_text(pic, "png");
               default: put_text(pic, "GIF");
            endcase
         end else begin
            put_text(pic, mimes[$urandom_range(5)]);
            append_byte(pic, 8'h00);
         end
         append_byte(pic, 8'($urandom));
         repeat ($urandom_range(0, 3)) begin
            append_byte(pic, 8'($urandom_range(1, 255)));
            if (enc == 1 || enc == 2) append_byte(pic, 8'($urandom));
         end
         append_byte(pic, 8'h00);
         if (enc == 1 || enc == 2) append_byte(pic, 8'h00);
         repeat ($urandom_range(1, 16)) append_byte(pic, 8'($urandom));
         put_frame_hdr(body, ver, (ver == 2) ? "PIC" : "APIC",
                       pic.size() + ((mode == 3) ? 40 : 0));
         body = {body, pic};
      end
      repeat ($urandom_range(0, 3)) append_byte(body, 8'h00);
      put_text(file_q, "ID3");
      append_byte(file_q, ver[7:0]);
      append_byte(file_q, 8'($urandom));
      append_byte(file_q, 8'($urandom & 32'hBF) | (ext ? 8'h40 : 8'h00));
      put_size(file_q, body.size(), 4, 1'b1);
      file_q = {file_q, body};
      repeat ($urandom_range(0, 4)) append_byte(file_q, 8'($urandom));
      if (mode == 1) begin
         n = $urandom_range(1, file_q.size() - 1);
         while (file_q.size() > n) void'(file_q.pop_back());
      end
      if (mode == 2) file_q[$urandom_range(0, file_q.size() - 1)] = 8'($urandom);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_q.size(); i++) begin
         if (!calm && $urandom_range(99) < 17) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
         end
         req_valid <= 1'b1;
         req_data <= '{data_byte: file_q[i], end_of_file: (i == file_q.size() - 1)};
         do @(posedge clock); while (req_stall);
         bytes_sent++;
      end
   endtask

   task automatic random_files(input int target);
      int mode;
      while (bytes_sent < target) begin
         mode = $urandom_range(0, 9);
         make_file($urandom_range(2, 4), $urandom_range(3) == 0, (mode < 5) ? 0 : mode - 4);
         send_file();
      end
   endtask

   task automatic drain_idle();
      req_valid <= 1'b0;
      repeat (2) @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_tag(input logic [27:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      calm = 1'b0;
      squeeze = 1'b0;
      bytes_sent = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // header rejects, cut headers and short tags at the reset limit, then sample files of several versions and modes
      header_only(1, 10, 2); send_file();
      header_only(5, 10, 2); send_file();
      header_only(3, 0, 2); send_file();
      header_only(3, 28'h0FFFFFF, 2); send_file();
      header_only(3, 10, 0); file_q[0] = "X"; send_file();
      header_only(3, 10, 0); void'(file_q.pop_back()); send_file();
      file_q = '{8'h00}; send_file();
      file_q = '{8'hFF, 8'hFF}; send_file();
      make_file(2, 0, 0); send_file();
      make_file(3, 0, 0); send_file();
      make_file(4, 1, 0); send_file();
      make_file(3, 0, 4); send_file();
      make_file(3, 0, 3); send_file();
      make_file(4, 0, 5); send_file();
      make_file(3, 0, 1); send_file();
      make_file(2, 1, 0); send_file();
      drain_idle();

      write_max_tag(28'd1);
      header_only(3, 1, 3); send_file();
      header_only(3, 2, 0); send_file();
      make_file(3, 0, 0); send_file();
      drain_idle();

      write_max_tag(28'hFFFFFFF);
      header_only(4, 28'hFFFFFFF, 3); send_file();
      squeeze = 1'b1;
      random_files(500);
      drain_idle();

      write_max_tag(28'd60);
      random_files(850);
      drain_idle();

      write_max_tag(MAX_TAG_RESET);
      calm = 1'b1;
      random_files(1000);
      calm = 1'b0;
      random_files(1250);
      drain_idle();
      repeat (10) @(posedge clock);

      if (errors == 0 && pending == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/id3_pkg.sv
design/id3_parser.sv
design/id3_rsp_fifo.sv
design/id3v2_picture_extractor_unit.sv
dv/id3_stream_checker.sv
dv/testbench.sv
